>>> sv/ppi_pkg.sv
// ----------------------------------------------------------------------------
// ppi_pkg: shared types, constants and functions
// Item and result structures, event and address codes, control word bits,
// and the mask and interrupt functions of the parallel interface.
// ----------------------------------------------------------------------------
package ppi_pkg;

    localparam logic [7:0] MODE_RESET = 8'h9B;

    // Port C bits taken by the group B and group A handshake lines.
    localparam logic [7:0] C_B_HS     = 8'h07;
    localparam logic [7:0] C_A_HS2    = 8'hF8;
    localparam logic [7:0] C_A_HS_IN  = 8'h38;
    localparam logic [7:0] C_A_HS_OUT = 8'hC8;
    localparam logic [7:0] C_LOWER    = 8'h0F;
    localparam logic [7:0] C_UPPER    = 8'hF0;

    // Control word bit positions.
    localparam int MW_SET      = 7;
    localparam int MW_A_MODE2  = 6;
    localparam int MW_A_MODE1  = 5;
    localparam int MW_A_INPUT  = 4;
    localparam int MW_CU_INPUT = 3;
    localparam int MW_B_MODE1  = 2;
    localparam int MW_B_INPUT  = 1;
    localparam int MW_CL_INPUT = 0;

    // Port C bit numbers that carry interrupt enables.
    localparam logic [2:0] C_BIT_ENB     = 3'd2;
    localparam logic [2:0] C_BIT_EN_IN   = 3'd4;
    localparam logic [2:0] C_BIT_EN_OUT  = 3'd6;

    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_STB_A = 3'd2,
        OP_STB_B = 3'd3,
        OP_ACK_A = 3'd4,
        OP_ACK_B = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ADDR_A    = 2'd0,
        ADDR_B    = 2'd1,
        ADDR_C    = 2'd2,
        ADDR_CTRL = 2'd3
    } addr_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] port_select;
        logic [7:0] write_data;
        logic [7:0] pins_a_in;
        logic [7:0] pins_b_in;
        logic [7:0] pins_c_in;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] port_a_out;
        logic [7:0] port_b_out;
        logic [7:0] port_c_out;
        logic [7:0] port_a_drive;
        logic [7:0] port_b_drive;
        logic [7:0] port_c_drive;
        logic       irq_a;
        logic       irq_b;
        logic       irq_rearm;
    } result_t;

    function automatic logic [7:0] mask_a(input logic [7:0] mw);
        return mw[MW_A_INPUT] ? 8'h00 : 8'hFF;
    endfunction

    function automatic logic [7:0] mask_b(input logic [7:0] mw);
        return mw[MW_B_INPUT] ? 8'h00 : 8'hFF;
    endfunction

    function automatic logic [7:0] mask_c(input logic [7:0] mw);
        logic [7:0] m;
        m = (mw[MW_CL_INPUT] ? 8'h00 : C_LOWER) | (mw[MW_CU_INPUT] ? 8'h00 : C_UPPER);
        if (mw[MW_B_MODE1])
            m = m & ~C_B_HS;
        if (mw[MW_A_MODE2])
            m = m & ~C_A_HS2;
        else if (mw[MW_A_MODE1])
            m = m & ~(mw[MW_A_INPUT] ? C_A_HS_IN : C_A_HS_OUT);
        return m;
    endfunction

    function automatic logic eval_a(input logic [7:0] mw, input logic en_a,
                                    input logic en_out2, input logic en_in2,
                                    input logic out_full, input logic in_full);
        logic r;
        if (mw[MW_A_MODE2])
            r = (en_out2 & ~out_full) ^ (en_in2 & in_full);
        else if (mw[MW_A_MODE1])
            r = mw[MW_A_INPUT] ? (en_a & in_full) : (en_a & ~out_full);
        else
            r = 1'b0;
        return r;
    endfunction

    function automatic logic eval_b(input logic [7:0] mw, input logic en_b,
                                    input logic out_full, input logic in_full);
        logic r;
        if (mw[MW_B_MODE1])
            r = mw[MW_B_INPUT] ? (en_b & in_full) : (en_b & ~out_full);
        else
            r = 1'b0;
        return r;
    endfunction

endpackage

>>> sv/ppi_core.sv
// ----------------------------------------------------------------------------
// ppi_core: interface state and event logic
// Holds the control word, port latches and handshake flags, and works out
// the result of one event combinationally from the current state.
// ----------------------------------------------------------------------------
module ppi_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  ppi_pkg::item_t   item,
    output ppi_pkg::result_t result
);
    import ppi_pkg::*;

    logic [7:0] mode_word_reg, mode_word_next;
    logic [7:0] latch_a_reg, latch_a_next;
    logic [7:0] latch_b_reg, latch_b_next;
    logic [7:0] latch_c_reg, latch_c_next;
    logic       out_full_a_reg, out_full_a_next;
    logic       out_full_b_reg, out_full_b_next;
    logic       enable_a_reg, enable_a_next;
    logic       enable_b_reg, enable_b_next;
    logic       enable_out2_reg, enable_out2_next;
    logic       enable_in2_reg, enable_in2_next;
    logic       request_a_reg, request_a_next;
    logic       request_b_reg, request_b_next;

    logic [7:0] ma, mb, mc;
    logic [7:0] rd;
    logic       rearm;
    logic [2:0] bit_sel;
    logic       bit_val;
    logic [7:0] bit_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_word_reg   <= MODE_RESET;
            latch_a_reg     <= '0;
            latch_b_reg     <= '0;
            latch_c_reg     <= '0;
            out_full_a_reg  <= 1'b0;
            out_full_b_reg  <= 1'b0;
            enable_a_reg    <= 1'b0;
            enable_b_reg    <= 1'b0;
            enable_out2_reg <= 1'b0;
            enable_in2_reg  <= 1'b0;
            request_a_reg   <= 1'b0;
            request_b_reg   <= 1'b0;
        end
        else if (step)
        begin
            mode_word_reg   <= mode_word_next;
            latch_a_reg     <= latch_a_next;
            latch_b_reg     <= latch_b_next;
            latch_c_reg     <= latch_c_next;
            out_full_a_reg  <= out_full_a_next;
            out_full_b_reg  <= out_full_b_next;
            enable_a_reg    <= enable_a_next;
            enable_b_reg    <= enable_b_next;
            enable_out2_reg <= enable_out2_next;
            enable_in2_reg  <= enable_in2_next;
            request_a_reg   <= request_a_next;
            request_b_reg   <= request_b_next;
        end
    end

    // The input buffer flags never outlive an event: a read or strobe raises them
    // only for its own interrupt evaluation, so they are constants here.
    always_comb
    begin
        mode_word_next   = mode_word_reg;
        latch_a_next     = latch_a_reg;
        latch_b_next     = latch_b_reg;
        latch_c_next     = latch_c_reg;
        out_full_a_next  = out_full_a_reg;
        out_full_b_next  = out_full_b_reg;
        enable_a_next    = enable_a_reg;
        enable_b_next    = enable_b_reg;
        enable_out2_next = enable_out2_reg;
        enable_in2_next  = enable_in2_reg;
        request_a_next   = request_a_reg;
        request_b_next   = request_b_reg;
        rd               = '0;
        rearm            = 1'b0;
        ma               = mask_a(mode_word_reg);
        mb               = mask_b(mode_word_reg);
        mc               = mask_c(mode_word_reg);
        bit_sel          = item.write_data[3:1];
        bit_val          = item.write_data[0];
        bit_mask         = (8'd1 << bit_sel) & mc;

        case (op_t'(item.mode))
            OP_READ, OP_STB_A, OP_STB_B:
            begin
                if ((op_t'(item.mode) == OP_STB_A) ||
                    (op_t'(item.mode) == OP_READ && addr_t'(item.port_select) == ADDR_A))
                begin
                    latch_a_next   = (latch_a_reg & ma) | (item.pins_a_in & ~ma);
                    request_a_next = eval_a(mode_word_reg, enable_a_reg, enable_out2_reg,
                                            enable_in2_reg, out_full_a_reg, 1'b1);
                end
                else if ((op_t'(item.mode) == OP_STB_B) ||
                         (op_t'(item.mode) == OP_READ &&
                          addr_t'(item.port_select) == ADDR_B))
                begin
                    latch_b_next   = (latch_b_reg & mb) | (item.pins_b_in & ~mb);
                    request_b_next = eval_b(mode_word_reg, enable_b_reg,
                                            out_full_b_reg, 1'b1);
                end
                else if (addr_t'(item.port_select) == ADDR_C)
                begin
                    latch_c_next = (latch_c_reg & mc) | (item.pins_c_in & ~mc);
                end
                if (op_t'(item.mode) == OP_READ)
                begin
                    case (addr_t'(item.port_select))
                        ADDR_A:    rd = latch_a_next;
                        ADDR_B:    rd = latch_b_next;
                        ADDR_C:    rd = latch_c_next;
                        ADDR_CTRL: rd = mode_word_reg;
                        default:   rd = '0;
                    endcase
                end
            end
            OP_WRITE:
            begin
                case (addr_t'(item.port_select))
                    ADDR_A:
                    begin
                        latch_a_next = (latch_a_reg & ~ma) | (item.write_data & ma);
                        if (ma != 8'h00)
                        begin
                            out_full_a_next = 1'b1;
                            request_a_next  = eval_a(mode_word_reg, enable_a_reg,
                                                     enable_out2_reg, enable_in2_reg,
                                                     1'b1, 1'b0);
                        end
                    end
                    ADDR_B:
                    begin
                        latch_b_next = (latch_b_reg & ~mb) | (item.write_data & mb);
                        if (mb != 8'h00)
                        begin
                            out_full_b_next = 1'b1;
                            request_b_next  = eval_b(mode_word_reg, enable_b_reg,
                                                     1'b1, 1'b0);
                        end
                    end
                    ADDR_C:
                    begin
                        latch_c_next = (latch_c_reg & ~mc) | (item.write_data & mc);
                    end
                    default:
                    begin
                        if (item.write_data[MW_SET])
                        begin
                            // Mode set: ports that become outputs start from zero.
                            mode_word_next = item.write_data;
                            latch_a_next   = latch_a_reg & ~mask_a(item.write_data);
                            latch_b_next   = latch_b_reg & ~mask_b(item.write_data);
                            latch_c_next   = latch_c_reg & ~mask_c(item.write_data);
                            request_a_next = eval_a(item.write_data, enable_a_reg,
                                                    enable_out2_reg, enable_in2_reg,
                                                    out_full_a_reg, 1'b0);
                            request_b_next = eval_b(item.write_data, enable_b_reg,
                                                    out_full_b_reg, 1'b0);
                            rearm          = 1'b1;
                        end
                        else
                        begin
                            // Bit set/reset: enable bits ride on port C bit numbers.
                            if (mode_word_reg[MW_A_MODE2])
                            begin
                                if (bit_sel == C_BIT_EN_IN)
                                begin
                                    enable_in2_next = bit_val;
                                    request_a_next  = eval_a(mode_word_reg, enable_a_reg,
                                                             enable_out2_reg, bit_val,
                                                             out_full_a_reg, 1'b0);
                                end
                                else if (bit_sel == C_BIT_EN_OUT)
                                begin
                                    enable_out2_next = bit_val;
                                    request_a_next   = eval_a(mode_word_reg, enable_a_reg,
                                                              bit_val, enable_in2_reg,
                                                              out_full_a_reg, 1'b0);
                                end
                            end
                            else if (mode_word_reg[MW_A_MODE1])
                            begin
                                if (bit_sel == (mode_word_reg[MW_A_INPUT] ?
                                                C_BIT_EN_IN : C_BIT_EN_OUT))
                                begin
                                    enable_a_next  = bit_val;
                                    request_a_next = eval_a(mode_word_reg, bit_val,
                                                            enable_out2_reg, enable_in2_reg,
                                                            out_full_a_reg, 1'b0);
                                end
                            end
                            if (mode_word_reg[MW_B_MODE1] && bit_sel == C_BIT_ENB)
                            begin
                                enable_b_next  = bit_val;
                                request_b_next = eval_b(mode_word_reg, bit_val,
                                                        out_full_b_reg, 1'b0);
                            end
                            latch_c_next = (latch_c_reg & ~bit_mask) |
                                           ({8{bit_val}} & bit_mask);
                        end
                    end
                endcase
            end
            OP_ACK_A:
            begin
                out_full_a_next = 1'b0;
                request_a_next  = eval_a(mode_word_reg, enable_a_reg, enable_out2_reg,
                                         enable_in2_reg, 1'b0, 1'b0);
            end
            OP_ACK_B:
            begin
                out_full_b_next = 1'b0;
                request_b_next  = eval_b(mode_word_reg, enable_b_reg, 1'b0, 1'b0);
            end
            default:
            begin
                rd = '0;
            end
        endcase

        result.read_data    = rd;
        result.port_a_out   = latch_a_next;
        result.port_b_out   = latch_b_next;
        result.port_c_out   = latch_c_next;
        result.port_a_drive = mask_a(mode_word_next);
        result.port_b_drive = mask_b(mode_word_next);
        result.port_c_drive = mask_c(mode_word_next);
        result.irq_a        = request_a_next;
        result.irq_b        = request_b_next;
        result.irq_rearm    = rearm;
    end

endmodule

>>> sv/programmable_peripheral_interface.sv
// ----------------------------------------------------------------------------
// programmable_peripheral_interface: three-port parallel interface
// Takes bus reads and writes and port handshake events as words and
// returns the port state after each one.
// ----------------------------------------------------------------------------
// Usage:
// Each input word is one event: a bus read or write at an address, a
// strobe on port A or B, or an acknowledge on port A or B, together with
// the present pin levels. Every accepted word yields exactly one output
// word with the read byte, the three port latches, their drive masks and
// the interrupt lines after the event.
// A word accepted at a clock edge sits in the input register, and once the
// output register is empty or being taken, an edge moves its result through
// the event logic into the output register, where out_valid presents it.
// Throughput is one word per cycle while out_ready stays high; the state
// update for a word completes in the same cycle its result is registered,
// so the next word follows without a gap.
// Reset sets the control word to 0x9B (all ports input), clears the
// latches and all handshake and enable flags, and empties both registers.
// When the receiver holds out_ready low, the output word stays in place,
// the input register keeps one further word, and in_ready then drops
// until the output is taken.
// ----------------------------------------------------------------------------
module programmable_peripheral_interface
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] mode,
    input  logic [1:0] port_select,
    input  logic [7:0] write_data,
    input  logic [7:0] pins_a_in,
    input  logic [7:0] pins_b_in,
    input  logic [7:0] pins_c_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic [7:0] port_a_out,
    output logic [7:0] port_b_out,
    output logic [7:0] port_c_out,
    output logic [7:0] port_a_drive,
    output logic [7:0] port_b_drive,
    output logic [7:0] port_c_drive,
    output logic       irq_a,
    output logic       irq_b,
    output logic       irq_rearm
);
    import ppi_pkg::*;

    item_t   item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t result_reg;
    logic    out_valid_reg, out_valid_next;
    result_t result;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next  = in_ready ? in_valid : in_valid_reg;
        out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.mode        <= mode;
            item_reg.port_select <= port_select;
            item_reg.write_data  <= write_data;
            item_reg.pins_a_in   <= pins_a_in;
            item_reg.pins_b_in   <= pins_b_in;
            item_reg.pins_c_in   <= pins_c_in;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    ppi_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (result)
    );

    assign out_valid    = out_valid_reg;
    assign read_data    = result_reg.read_data;
    assign port_a_out   = result_reg.port_a_out;
    assign port_b_out   = result_reg.port_b_out;
    assign port_c_out   = result_reg.port_c_out;
    assign port_a_drive = result_reg.port_a_drive;
    assign port_b_drive = result_reg.port_b_drive;
    assign port_c_drive = result_reg.port_c_drive;
    assign irq_a        = result_reg.irq_a;
    assign irq_b        = result_reg.irq_b;
    assign irq_rearm    = result_reg.irq_rearm;

endmodule
